@@ rtl/v3n_pkg.sv @@
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants for vector3_normalize
// Widths of the fixed-point fields and of the lane arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package v3n_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 14;

  localparam int OUT_WIDTH = OUT_FRAC_BITS + 2;
  localparam int MAG_W     = IN_WIDTH;
  localparam int SQ_W      = 2 * IN_WIDTH;
  localparam int S_W       = 2 * IN_WIDTH + 2;
  localparam int Q_W       = OUT_FRAC_BITS + 1;
  // holds (2q-1)^2 * s for any candidate, plus sign
  localparam int ACC_W     = 2 * OUT_FRAC_BITS + 2 * IN_WIDTH + 8;

  // one stage per quotient bit
  localparam int LANE_STAGES = OUT_FRAC_BITS + 1;
  // front (2) + lane + output register
  localparam int LATENCY     = LANE_STAGES + 3;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/v3n_front.sv @@
// ----------------------------------------------------------------------------
// v3n_front: magnitude, squares and sum of squares
// Two register stages; hands one word per cycle to the three lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3n_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_vld,
  input  wire logic signed [v3n_pkg::IN_WIDTH-1:0] in_comp [3],
  output logic                                     out_vld,
  output v3n_pkg::side_t                           out_side [3],
  output logic [v3n_pkg::SQ_W-1:0]                 out_sq [3],
  output logic [v3n_pkg::S_W-1:0]                  out_s
);
  import v3n_pkg::*;

  logic              vld1_r;
  logic              neg1_r [3];
  logic [SQ_W-1:0]   sq1_r  [3];
  logic              vld2_r;
  side_t             side2_r [3];
  logic [SQ_W-1:0]   sq2_r  [3];
  logic [S_W-1:0]    s2_r;
  logic [MAG_W-1:0]  mag    [3];
  logic [S_W-1:0]    s_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_comp[i][IN_WIDTH-1] ? MAG_W'(-in_comp[i]) : MAG_W'(in_comp[i]);
    end
    s_nxt = S_W'(sq1_r[0]) + S_W'(sq1_r[1]) + S_W'(sq1_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg1_r[i]        <= in_comp[i][IN_WIDTH-1];
      sq1_r[i]         <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
      sq2_r[i]         <= sq1_r[i];
      side2_r[i].neg   <= neg1_r[i];
      side2_r[i].zero  <= (s_nxt == '0);
    end
    s2_r <= s_nxt;
  end

  assign out_vld  = vld2_r;
  assign out_side = side2_r;
  assign out_sq   = sq2_r;
  assign out_s    = s2_r;

endmodule

`default_nettype wire

@@ rtl/v3n_lane.sv @@
// ----------------------------------------------------------------------------
// v3n_lane: one component, c * 2^F / sqrt(s), rounded to nearest
// Restoring bit search, one quotient bit per stage, fully pipelined.
// Test per bit: (2q-1)^2 * s <= c^2 * 2^(2F+2), kept incrementally with
// a = u^2*s and b = u*s (u = 2q-1), so each stage is shifts and adds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3n_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire v3n_pkg::side_t                in_side,
  input  wire logic [v3n_pkg::SQ_W-1:0]      in_sq,
  input  wire logic [v3n_pkg::S_W-1:0]       in_s,
  output logic                               out_vld,
  output v3n_pkg::side_t                     out_side,
  output logic [v3n_pkg::Q_W-1:0]            out_q
);
  import v3n_pkg::*;

  localparam int N = LANE_STAGES;

  logic           vld_r  [N];
  side_t          side_r [N];
  logic [Q_W-1:0] q_r    [N];
  acc_t           a_r    [N];
  acc_t           b_r    [N];
  acc_t           t_r    [N];
  acc_t           s_r    [N];

  acc_t s_ext;
  assign s_ext = $signed({{(ACC_W-S_W){1'b0}}, in_s});

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int BIT = OUT_FRAC_BITS - k;

    logic           vld_i;
    side_t          side_i;
    logic [Q_W-1:0] q_i;
    acc_t           a_i, b_i, t_i, s_i, test;
    logic           take;

    if (k == 0) begin : g_head
      // u = -1 at start: a = s, b = -s
      assign vld_i  = in_vld;
      assign side_i = in_side;
      assign q_i    = '0;
      assign a_i    = s_ext;
      assign b_i    = -s_ext;
      assign s_i    = s_ext;
      assign t_i    = $signed({{(ACC_W-SQ_W){1'b0}}, in_sq}) <<< (2 * OUT_FRAC_BITS + 2);
    end else begin : g_body
      assign vld_i  = vld_r[k-1];
      assign side_i = side_r[k-1];
      assign q_i    = q_r[k-1];
      assign a_i    = a_r[k-1];
      assign b_i    = b_r[k-1];
      assign s_i    = s_r[k-1];
      assign t_i    = t_r[k-1];
    end

    always_comb begin
      test = a_i + (b_i <<< (BIT + 2)) + (s_i <<< (2 * BIT + 2));
      // once q reaches 2^F no further bit may be set
      take = !q_i[OUT_FRAC_BITS] && (test <= t_i);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_i;
      s_r[k]    <= s_i;
      t_r[k]    <= t_i;
      if (take) begin
        q_r[k] <= q_i | (Q_W'(1) << BIT);
        a_r[k] <= test;
        b_r[k] <= b_i + (s_i <<< (BIT + 1));
      end else begin
        q_r[k] <= q_i;
        a_r[k] <= a_i;
        b_r[k] <= b_i;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_q    = q_r[N-1];

endmodule

`default_nettype wire

@@ rtl/v3n_merge.sv @@
// ----------------------------------------------------------------------------
// v3n_merge: joins the three lanes into one result word
// Applies signs, forces zero for a zero-length vector, registers outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3n_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_vld,
  input  wire v3n_pkg::side_t                       in_side [3],
  input  wire logic [v3n_pkg::Q_W-1:0]              in_q [3],
  output logic                                      out_valid,
  output logic signed [v3n_pkg::OUT_WIDTH-1:0]      out_unit [3],
  output logic                                      out_zero_length
);
  import v3n_pkg::*;

  logic                        valid_r;
  logic signed [OUT_WIDTH-1:0] unit_r [3];
  logic                        zero_r;
  logic signed [OUT_WIDTH-1:0] unit_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_side[0].zero) begin
        unit_nxt[i] = '0;
      end else if (in_side[i].neg) begin
        unit_nxt[i] = -$signed({1'b0, in_q[i]});
      end else begin
        unit_nxt[i] = $signed({1'b0, in_q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    zero_r <= in_side[0].zero;
  end

  assign out_valid       = valid_r;
  assign out_unit        = unit_r;
  assign out_zero_length = zero_r;

endmodule

`default_nettype wire

@@ rtl/vector3_normalize.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize: 3D vector to unit length, Q8.8 in, Q1.14 out
// Three parallel lanes, one per component, after a shared sum-of-squares.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_comp_x/y/z                           start & !busy
//  result    out_unit_x/y/z, out_zero_length         out_valid, one cycle
//
//  One vector per cycle; busy is always low.
//  Pipeline: 2 front stages, 15 lane stages (one per quotient
//  bit of the shift-add square-root divide), 1 output register.
//  Synchronous reset clears the valid pipeline only.
//  The receiver cannot stall; each result appears for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vector3_normalize (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]   in_comp_x,
  input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]   in_comp_y,
  input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]   in_comp_z,
  output logic                                       out_valid,
  output logic signed [v3n_pkg::OUT_WIDTH-1:0]       out_unit_x,
  output logic signed [v3n_pkg::OUT_WIDTH-1:0]       out_unit_y,
  output logic signed [v3n_pkg::OUT_WIDTH-1:0]       out_unit_z,
  output logic                                       out_zero_length
);
  import v3n_pkg::*;

  logic signed [IN_WIDTH-1:0]  comp [3];
  logic                        f_vld;
  side_t                       f_side [3];
  logic [SQ_W-1:0]             f_sq [3];
  logic [S_W-1:0]              f_s;
  logic                        l_vld [3];
  side_t                       l_side [3];
  logic [Q_W-1:0]              l_q [3];
  logic signed [OUT_WIDTH-1:0] unit [3];

  assign busy    = 1'b0;
  assign comp[0] = in_comp_x;
  assign comp[1] = in_comp_y;
  assign comp[2] = in_comp_z;

  v3n_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_comp  (comp),
    .out_vld  (f_vld),
    .out_side (f_side),
    .out_sq   (f_sq),
    .out_s    (f_s)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3n_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (f_vld),
      .in_side  (f_side[i]),
      .in_sq    (f_sq[i]),
      .in_s     (f_s),
      .out_vld  (l_vld[i]),
      .out_side (l_side[i]),
      .out_q    (l_q[i])
    );
  end

  v3n_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (l_vld[0]),
    .in_side         (l_side),
    .in_q            (l_q),
    .out_valid       (out_valid),
    .out_unit        (unit),
    .out_zero_length (out_zero_length)
  );

  assign out_unit_x = unit[0];
  assign out_unit_y = unit[1];
  assign out_unit_z = unit[2];

endmodule

`default_nettype wire

@@ rtl/v3n_check.sv @@
// ----------------------------------------------------------------------------
// v3n_check: port-level checks for vector3_normalize
// Latency, zero-length forcing, output range and nonzero results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3n_check (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  start,
  input wire logic                                  busy,
  input wire logic                                  out_valid,
  input wire logic signed [v3n_pkg::OUT_WIDTH-1:0]  out_unit_x,
  input wire logic signed [v3n_pkg::OUT_WIDTH-1:0]  out_unit_y,
  input wire logic signed [v3n_pkg::OUT_WIDTH-1:0]  out_unit_z,
  input wire logic                                  out_zero_length
);
  import v3n_pkg::*;

  localparam logic signed [OUT_WIDTH-1:0] ONE  = OUT_WIDTH'(1) << OUT_FRAC_BITS;
  localparam logic signed [OUT_WIDTH-1:0] MONE = -ONE;

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after accepted word");

  a_zero_forced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0))
    else $error("zero-length vector with nonzero components");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_unit_x <= ONE && out_unit_x >= MONE &&
                   out_unit_y <= ONE && out_unit_y >= MONE &&
                   out_unit_z <= ONE && out_unit_z >= MONE))
    else $error("unit component out of range");

  // nonzero vector has at least one nonzero component (the largest is about 1/sqrt(3) or more)
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_length) |->
      (out_unit_x != '0 || out_unit_y != '0 || out_unit_z != '0))
    else $error("nonzero vector normalized to all zero");

endmodule

bind vector3_normalize v3n_check u_v3n_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_unit_x      (out_unit_x),
  .out_unit_y      (out_unit_y),
  .out_unit_z      (out_unit_z),
  .out_zero_length (out_zero_length)
);

`default_nettype wire

@@ sim/vector3_normalize_tb.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize_tb: self-checking bench for vector3_normalize
// Drives Q8.8 vectors with random gaps, predicts the rounded Q1.14 unit
// vector per word and checks every strobed result against the oldest
// prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector3_normalize_tb;
  import v3n_pkg::*;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] ux;
    logic signed [OUT_WIDTH-1:0] uy;
    logic signed [OUT_WIDTH-1:0] uz;
    logic                        zl;
  } unit_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_WIDTH-1:0] in_comp_x = '0;
  logic signed [IN_WIDTH-1:0] in_comp_y = '0;
  logic signed [IN_WIDTH-1:0] in_comp_z = '0;
  logic out_valid;
  logic signed [OUT_WIDTH-1:0] out_unit_x, out_unit_y, out_unit_z;
  logic out_zero_length;

  unit_vec_t pending_units[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        no_gaps = 0;

  localparam int CYCLE_LIMIT = 200000;

  vector3_normalize dut (
    .clk, .rst_n, .start, .busy, .in_comp_x, .in_comp_y, .in_comp_z,
    .out_valid, .out_unit_x, .out_unit_y, .out_unit_z, .out_zero_length
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [IN_WIDTH:0] magnitude(logic signed [IN_WIDTH-1:0] c);
    return (c < 0) ? -{c[IN_WIDTH-1], c} : {1'b0, c};
  endfunction

  // nearest integer to mag * 2^F / sqrt(s), ties away from zero:
  // largest q with (2q-1)^2 * s <= mag^2 * 2^(2F+2)
  function automatic logic [OUT_WIDTH-1:0] scaled_mag(logic [IN_WIDTH:0] mag,
                                                     logic [63:0] s);
    logic [127:0] goal;
    logic [127:0] trial;
    logic [31:0]  q;
    logic [31:0]  cand;
    goal = ({64'd0, 64'(mag) * 64'(mag)}) << (2 * OUT_FRAC_BITS + 2);
    q = 0;
    for (int b = OUT_FRAC_BITS; b >= 0; b--) begin
      cand = q | (32'd1 << b);
      if (cand <= (32'd1 << OUT_FRAC_BITS)) begin
        trial = 128'(2 * cand - 1) * 128'(2 * cand - 1) * 128'(s);
        if (trial <= goal) q = cand;
      end
    end
    return q[OUT_WIDTH-1:0];
  endfunction

  function automatic unit_vec_t normalized(logic signed [IN_WIDTH-1:0] x,
                                           logic signed [IN_WIDTH-1:0] y,
                                           logic signed [IN_WIDTH-1:0] z);
    unit_vec_t r;
    logic [63:0] s;
    logic [IN_WIDTH:0] mx, my, mz;
    mx = magnitude(x);
    my = magnitude(y);
    mz = magnitude(z);
    s = 64'(mx) * mx + 64'(my) * my + 64'(mz) * mz;
    r = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
    if (s != 0) begin
      r.zl = 1'b0;
      r.ux = (x < 0) ? -scaled_mag(mx, s) : scaled_mag(mx, s);
      r.uy = (y < 0) ? -scaled_mag(my, s) : scaled_mag(my, s);
      r.uz = (z < 0) ? -scaled_mag(mz, s) : scaled_mag(mz, s);
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    unit_vec_t want;
    if (rst_n && out_valid) begin
      if (pending_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %0d %0d %0d %b",
                                       out_unit_x, out_unit_y, out_unit_z, out_zero_length);
      end else begin
        want = pending_units.pop_front();
        if (want.ux !== out_unit_x || want.uy !== out_unit_y ||
            want.uz !== out_unit_z || want.zl !== out_zero_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %b got %0d %0d %0d %b",
                     want.ux, want.uy, want.uz, want.zl,
                     out_unit_x, out_unit_y, out_unit_z, out_zero_length);
        end
      end
    end
  end

  task automatic send_vector(input logic signed [IN_WIDTH-1:0] x,
                             input logic signed [IN_WIDTH-1:0] y,
                             input logic signed [IN_WIDTH-1:0] z);
    while (!no_gaps && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_comp_x <= x;
    in_comp_y <= y;
    in_comp_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_units.push_back(normalized(x, y, z));
  endtask

  task automatic test_corners();
    send_vector(0, 0, 0);
    send_vector(16'sh7fff, 0, 0);
    send_vector(0, -16'sh8000, 0);
    send_vector(0, 0, 1);
    send_vector(0, 0, -1);
    send_vector(-16'sh8000, -16'sh8000, -16'sh8000);
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vector(-16'sh8000, 16'sh7fff, 0);
    send_vector(1, 1, 1);
    send_vector(-1, 1, -1);
    send_vector(256, 0, 256);
    send_vector(3, 4, 0);
    send_vector(16'sh7fff, 1, -1);
    send_vector(-16'sh8000, 0, 1);
    send_vector(16'sh5555, -16'sh2aab, 16'sh00ff);
  endtask

  task automatic test_random(input int count);
    logic signed [IN_WIDTH-1:0] c[3];
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 2) && (i < count / 2 + 60);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(4))
          0:       c[k] = $urandom_range(7) - 3;
          1:       c[k] = 0;
          default: c[k] = $urandom;
        endcase
      end
      send_vector(c[0], c[1], c[2]);
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random(450);
    start <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
